// ===== rtl/ctta_pkg.sv =====
package ctta_pkg;

    localparam int CFG_W   = 13;
    localparam int COORD_W = 12;
    localparam int IDX_W   = 24;

    localparam logic CFG_MATRIX_SIZE = 1'b0;
    localparam logic CFG_TILE_SIZE   = 1'b1;

    typedef struct packed {
        logic               vld;
        logic               oor;
        logic [CFG_W-1:0]   n;
        logic [CFG_W-1:0]   k;
        logic [COORD_W-1:0] rrem;
        logic [COORD_W-1:0] crem;
        logic [COORD_W-1:0] tr;
        logic [COORD_W-1:0] tc;
        logic [CFG_W-1:0]   trk;
        logic [CFG_W-1:0]   tck;
        logic [CFG_W-1:0]   th;
        logic [CFG_W-1:0]   tw;
        logic [IDX_W-1:0]   p1;
        logic [IDX_W-1:0]   p2;
        logic [IDX_W-1:0]   p3;
        logic [IDX_W-1:0]   idx;
        logic [IDX_W-1:0]   irem;
        logic [COORD_W-1:0] q;
    } t_pipe;

endpackage

// ===== rtl/ctta_if.sv =====
interface ctta_in_if;
    import ctta_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    modport source(output valid, output row, output col, input ready);
    modport sink(input valid, input row, input col, output ready);
endinterface

interface ctta_out_if;
    import ctta_pkg::*;
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   tiled_index;
    logic [COORD_W-1:0] tiled_row;
    logic [COORD_W-1:0] tiled_col;
    logic               out_of_range;
    modport source(output valid, output tiled_index, output tiled_row, output tiled_col,
                   output out_of_range, input ready);
    modport sink(input valid, input tiled_index, input tiled_row, input tiled_col,
                 input out_of_range, output ready);
endinterface

// ===== rtl/column_to_tiled_address.sv =====
// Throughput: one item per cycle unless the pipeline holds; a chain of 12 restoring-divide
// cells splits the coordinates by the tile size, a second chain of 12 splits the index by
// the matrix size. The whole pipeline holds while a finished result waits for the sink.
// Reset (synchronous, active low) empties the pipeline and sets matrix size 4096, tile 64.
module column_to_tiled_address #(
    parameter int MAX_DIM = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [ctta_pkg::CFG_W-1:0] i_cfg_data,
    ctta_in_if.sink                   i_in,
    ctta_out_if.source                o_out
);
    import ctta_pkg::*;

    logic [CFG_W-1:0] r_msize;
    logic [CFG_W-1:0] r_tsize;
    logic             en;
    t_pipe            r_s0, n_s0;
    t_pipe            r_s1, n_s1;
    t_pipe            r_s2, n_s2;
    t_pipe            r_s3, n_s3;
    t_pipe            r_s4, n_s4;
    t_pipe            s_a [0:COORD_W];
    t_pipe            s_b [0:COORD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msize <= 13'd4096;
            r_tsize <= 13'd64;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MATRIX_SIZE) begin
                r_msize <= i_cfg_data;
            end else begin
                r_tsize <= i_cfg_data;
            end
        end
    end

    assign en         = !s_b[COORD_W].vld || o_out.ready;
    assign i_in.ready = en;

    always_comb begin
        n_s0      = '0;
        n_s0.vld  = i_in.valid;
        n_s0.n    = (32'(r_msize) > MAX_DIM) ? CFG_W'(MAX_DIM) : r_msize;
        n_s0.k    = (r_tsize == '0) ? CFG_W'(1) : r_tsize;
        n_s0.oor  = (CFG_W'(i_in.row) >= n_s0.n) || (CFG_W'(i_in.col) >= n_s0.n);
        n_s0.rrem = i_in.row;
        n_s0.crem = i_in.col;
    end

    assign s_a[0] = r_s0;

    genvar gi;
    generate
        for (gi = 0; gi < COORD_W; gi++) begin : g_tile_div
            ctta_div_cell #(.KIND(0), .BIT(COORD_W-1-gi)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (en),
                .i_s    (s_a[gi]),
                .o_s    (s_a[gi+1])
            );
        end
    endgenerate

    always_comb begin
        n_s1     = s_a[COORD_W];
        n_s1.trk = CFG_W'(25'(n_s1.tr) * 25'(n_s1.k));
        n_s1.tck = CFG_W'(25'(n_s1.tc) * 25'(n_s1.k));
    end

    always_comb begin
        n_s2    = r_s1;
        n_s2.th = ((r_s1.n - r_s1.trk) < r_s1.k) ? (r_s1.n - r_s1.trk) : r_s1.k;
        n_s2.tw = ((r_s1.n - r_s1.tck) < r_s1.k) ? (r_s1.n - r_s1.tck) : r_s1.k;
    end

    always_comb begin
        n_s3    = r_s2;
        n_s3.p1 = IDX_W'(26'(r_s2.n) * 26'(r_s2.tck));
        n_s3.p2 = IDX_W'(26'(r_s2.trk) * 26'(r_s2.tw));
        n_s3.p3 = IDX_W'(26'(r_s2.th) * 26'(r_s2.crem));
    end

    always_comb begin
        n_s4      = r_s3;
        n_s4.idx  = r_s3.p1 + r_s3.p2 + r_s3.p3 + IDX_W'(r_s3.rrem);
        n_s4.irem = n_s4.idx;
        n_s4.q    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.vld <= 1'b0;
            r_s1.vld <= 1'b0;
            r_s2.vld <= 1'b0;
            r_s3.vld <= 1'b0;
            r_s4.vld <= 1'b0;
        end else if (en) begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
        end
    end

    assign s_b[0] = r_s4;

    generate
        for (gi = 0; gi < COORD_W; gi++) begin : g_size_div
            ctta_div_cell #(.KIND(1), .BIT(COORD_W-1-gi)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (en),
                .i_s    (s_b[gi]),
                .o_s    (s_b[gi+1])
            );
        end
    endgenerate

    assign o_out.valid        = s_b[COORD_W].vld;
    assign o_out.out_of_range = s_b[COORD_W].oor;
    assign o_out.tiled_index  = s_b[COORD_W].oor ? '0 : s_b[COORD_W].idx;
    assign o_out.tiled_row    = s_b[COORD_W].oor ? '0 : COORD_W'(s_b[COORD_W].irem);
    assign o_out.tiled_col    = s_b[COORD_W].oor ? '0 : s_b[COORD_W].q;

endmodule

// ===== rtl/ctta_div_cell.sv =====
module ctta_div_cell #(
    parameter int KIND = 0,
    parameter int BIT  = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  ctta_pkg::t_pipe i_s,
    output ctta_pkg::t_pipe o_s
);
    import ctta_pkg::*;

    t_pipe             r_s;
    t_pipe             n_s;
    logic [24:0]       dk;
    logic [36:0]       dn;

    always_comb begin
        n_s = i_s;
        dk  = 25'(i_s.k) << BIT;
        dn  = 37'(i_s.n) << BIT;
        if (KIND == 0) begin
            if (25'(i_s.rrem) >= dk) begin
                n_s.rrem     = COORD_W'(25'(i_s.rrem) - dk);
                n_s.tr[BIT]  = 1'b1;
            end
            if (25'(i_s.crem) >= dk) begin
                n_s.crem     = COORD_W'(25'(i_s.crem) - dk);
                n_s.tc[BIT]  = 1'b1;
            end
        end else begin
            if (37'(i_s.irem) >= dn) begin
                n_s.irem     = IDX_W'(37'(i_s.irem) - dn);
                n_s.q[BIT]   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s.vld <= 1'b0;
        end else if (i_en) begin
            r_s <= n_s;
        end
    end

    assign o_s = r_s;

endmodule
